@@ hw/rtl/ttlrc_pkg.sv @@
// Package of the TTL result cache tag table: opcodes, status codes, types.
// Used by the cell and the top level; no dependencies.
package ttlrc_pkg;

    localparam logic [2:0] OP_LOOKUP     = 3'd0;
    localparam logic [2:0] OP_STORE      = 3'd1;
    localparam logic [2:0] OP_INVALIDATE = 3'd2;
    localparam logic [2:0] OP_RELEASE    = 3'd3;
    localparam logic [2:0] OP_TOTALS     = 3'd4;

    localparam logic [3:0] ST_HIT         = 4'd0;
    localparam logic [3:0] ST_MISS        = 4'd1;
    localparam logic [3:0] ST_STORED      = 4'd2;
    localparam logic [3:0] ST_SKIPPED     = 4'd3;
    localparam logic [3:0] ST_EVICT_SKIP  = 4'd4;
    localparam logic [3:0] ST_INVALIDATED = 4'd5;
    localparam logic [3:0] ST_NOT_FOUND   = 4'd6;
    localparam logic [3:0] ST_RELEASED    = 4'd7;
    localparam logic [3:0] ST_TOTALS      = 4'd8;

    localparam logic [1:0] CFG_TTL       = 2'd0;
    localparam logic [1:0] CFG_MAX_ROWS  = 2'd1;
    localparam logic [1:0] CFG_MAX_BYTES = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_APPLY,
        S_OUT
    } state_t;

    // Slot contents handed along the chain.
    typedef struct packed {
        logic [63:0] key;
        logic [63:0] created;
        logic [15:0] refs;
        logic [31:0] hits;
        logic [15:0] rows;
        logic [11:0] cols;
    } slot_t;

    // Update command to the cell fed by the chain head (cell 0).
    typedef struct packed {
        logic        clear_free;  // clear if unreferenced
        logic        write;       // write a new entry
        logic        hit;         // raise refs and hits
        logic        dec_ref;     // decrement refs
        logic [63:0] key;
        logic [63:0] created;
        logic [15:0] rows;
        logic [11:0] cols;
    } upd_t;

endpackage

@@ hw/rtl/ttlrc_cell.sv @@
// One slot cell of the rotating tag chain; applies the head update on shift.
// Depends on ttlrc_pkg.
module ttlrc_cell (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            shift,
    input  logic            is_head,
    input  ttlrc_pkg::upd_t upd,
    input  ttlrc_pkg::slot_t prev_slot,
    output ttlrc_pkg::slot_t slot
);

    ttlrc_pkg::slot_t slot_reg;
    ttlrc_pkg::slot_t slot_next;

    // Modify the entry leaving the head, otherwise take the neighbor
    always_comb begin
        slot_next = prev_slot;
        if (is_head) begin
            if (upd.clear_free && prev_slot.refs == 16'd0) begin
                slot_next.key  = '0;
                slot_next.rows = '0;
                slot_next.cols = '0;
            end
            if (upd.hit) begin
                if (prev_slot.refs != 16'hFFFF) begin
                    slot_next.refs = prev_slot.refs + 16'd1;
                end
                slot_next.hits = prev_slot.hits + 32'd1;
            end
            if (upd.dec_ref && prev_slot.refs != 16'd0) begin
                slot_next.refs = prev_slot.refs - 16'd1;
            end
            if (upd.write) begin
                slot_next.key     = upd.key;
                slot_next.created = upd.created;
                slot_next.refs    = '0;
                slot_next.hits    = '0;
                slot_next.rows    = upd.rows;
                slot_next.cols    = upd.cols;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_reg <= '0;
        end else if (shift) begin
            slot_reg <= slot_next;
        end
    end

    assign slot = slot_reg;

endmodule

@@ hw/rtl/ttl_refcount_result_cache_tags_unit.sv @@
// Top level of the TTL result cache tag table: handshake, scan control, totals.
// Depends on ttlrc_pkg and ttlrc_cell.
//
//  channel  | direction | payload
//  s_axis   | in        | tdata: opcode,key,now_ms,slot_in,query_ok,row,col,byte
//  m_axis   | out       | tdata: status,slot_out,rows_out,cols_out,hit,miss
//  cfg      | in        | cfg_we, cfg_index, cfg_wdata
//
// The slots sit in a ring of ENTRIES cells that rotates one place a cycle in
// S_SCAN and S_APPLY. A transaction takes one full rotation to scan (slot 0 at
// the head first), one rotation to apply the update at the chosen slot, then
// S_OUT registers the result and raises m_tvalid. Reset empties every slot
// at once. One item is in flight; s_tready rises the cycle after the result
// is taken, and while m_tready is low the result is held.
module ttl_refcount_result_cache_tags_unit #(
    parameter int ENTRIES = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // opcode[2:0] key[66:3] now_ms[130:67] slot_in[134:131] query_ok[135]
    // row_count[151:136] col_count[163:152] byte_count[195:164]
    input  logic [199:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // status[3:0] slot_out[7:4] rows_out[23:8] cols_out[35:24]
    // hit_total[99:36] miss_total[163:100]
    output logic [167:0] m_tdata,
    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [31:0]  cfg_wdata
);

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(ENTRIES + 1);

    // Configuration registers
    logic [31:0] ttl_reg, max_bytes_reg;
    logic [15:0] max_rows_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ttl_reg       <= 32'd1000;
            max_rows_reg  <= 16'd1000;
            max_bytes_reg <= 32'd1048576;
        end else if (cfg_we) begin
            unique case (cfg_index)
                ttlrc_pkg::CFG_TTL:       ttl_reg       <= cfg_wdata;
                ttlrc_pkg::CFG_MAX_ROWS:  max_rows_reg  <= cfg_wdata[15:0];
                ttlrc_pkg::CFG_MAX_BYTES: max_bytes_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Item fields held for the whole operation
    logic [2:0]  op_reg;
    logic [63:0] key_reg, now_reg;
    logic [3:0]  sin_reg;
    logic        ok_reg;
    logic [15:0] rows_reg;
    logic [11:0] cols_reg;
    logic [31:0] bytes_reg;

    ttlrc_pkg::state_t state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;

    // Scan results
    logic          found_reg, found_next;
    logic [IW-1:0] tgt_reg, tgt_next;
    logic          stop_reg, stop_next;
    logic [63:0]   oldest_reg, oldest_next;
    logic          valid_age_reg, valid_age_next;
    logic [15:0]   hrows_reg, hrows_next;
    logic [11:0]   hcols_reg, hcols_next;

    logic [63:0] hit_tot_reg, miss_tot_reg;
    logic        mv_reg;
    logic [3:0]  status_reg;
    logic [3:0]  slot_out_reg;
    logic [15:0] rout_reg;
    logic [11:0] cout_reg;

    ttlrc_pkg::slot_t ring [ENTRIES];
    ttlrc_pkg::upd_t  upd;
    logic             shift;
    logic             head_sel;
    ttlrc_pkg::slot_t head;
    logic [63:0]      age;

    assign head = ring[ENTRIES-1];
    assign age  = now_reg - head.created;

    logic store_ok;
    assign store_ok = ok_reg && rows_reg != 16'd0 && rows_reg <= max_rows_reg
                      && key_reg != 64'd0;

    logic in_acc;
    assign in_acc   = s_tvalid && s_tready;
    assign s_tready = (state_reg == ttlrc_pkg::S_IDLE) && !mv_reg;
    assign shift    = (state_reg == ttlrc_pkg::S_SCAN)
                      || (state_reg == ttlrc_pkg::S_APPLY);

    // Chain of cells; head is the last cell, feeding cell 0 which applies updates
    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        ttlrc_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .shift     (shift),
            .is_head   (head_sel && (g == 0)),
            .upd       (upd),
            .prev_slot ((g == 0) ? ring[ENTRIES-1] : ring[(g == 0) ? 0 : g-1]),
            .slot      (ring[g])
        );
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ttlrc_pkg::S_IDLE:  if (in_acc) state_next = ttlrc_pkg::S_SCAN;
            ttlrc_pkg::S_SCAN:  if (cnt_reg == CW'(ENTRIES - 1))
                                    state_next = ttlrc_pkg::S_APPLY;
            ttlrc_pkg::S_APPLY: if (cnt_reg == CW'(ENTRIES - 1))
                                    state_next = ttlrc_pkg::S_OUT;
            ttlrc_pkg::S_OUT:   state_next = ttlrc_pkg::S_IDLE;
            default:            state_next = ttlrc_pkg::S_IDLE;
        endcase
    end

    // Scan datapath: head holds slot cnt_reg
    always_comb begin
        cnt_next       = (state_reg == ttlrc_pkg::S_SCAN
                          || state_reg == ttlrc_pkg::S_APPLY)
                         ? ((cnt_reg == CW'(ENTRIES - 1)) ? '0 : cnt_reg + CW'(1))
                         : '0;
        found_next     = found_reg;
        tgt_next       = tgt_reg;
        stop_next      = stop_reg;
        oldest_next    = oldest_reg;
        valid_age_next = valid_age_reg;
        hrows_next     = hrows_reg;
        hcols_next     = hcols_reg;
        if (state_reg == ttlrc_pkg::S_IDLE) begin
            found_next  = 1'b0;
            tgt_next    = '0;
            stop_next   = 1'b0;
            oldest_next = '1;
        end else if (state_reg == ttlrc_pkg::S_SCAN && !stop_reg) begin
            if (op_reg == ttlrc_pkg::OP_STORE) begin
                if (head.key == key_reg || head.key == 64'd0) begin
                    tgt_next  = cnt_reg[IW-1:0];
                    stop_next = 1'b1;
                end else if (head.created < oldest_reg) begin
                    oldest_next = head.created;
                    tgt_next    = cnt_reg[IW-1:0];
                end
            end else if (head.key == key_reg) begin
                found_next     = 1'b1;
                stop_next      = 1'b1;
                tgt_next       = cnt_reg[IW-1:0];
                valid_age_next = age < {32'd0, ttl_reg};
                hrows_next     = head.rows;
                hcols_next     = head.cols;
            end
        end
    end

    // Update command at the apply pass
    logic lk_hit;
    assign lk_hit = op_reg == ttlrc_pkg::OP_LOOKUP && key_reg != 64'd0
                    && found_reg && valid_age_reg;
    logic rel_ok;
    assign rel_ok = {5'd0, sin_reg} < 9'(ENTRIES);

    always_comb begin
        head_sel = 1'b0;
        upd      = '0;
        upd.key     = key_reg;
        upd.created = now_reg;
        upd.rows    = rows_reg;
        upd.cols    = cols_reg;
        if (state_reg == ttlrc_pkg::S_APPLY) begin
            head_sel = cnt_reg[IW-1:0] == tgt_reg;
            case (op_reg)
                ttlrc_pkg::OP_LOOKUP: begin
                    upd.hit        = lk_hit;
                    upd.clear_free = key_reg != 64'd0 && found_reg && !valid_age_reg;
                end
                ttlrc_pkg::OP_STORE: begin
                    upd.clear_free = store_ok;
                    upd.write      = store_ok && bytes_reg <= max_bytes_reg;
                end
                ttlrc_pkg::OP_INVALIDATE: begin
                    upd.clear_free = key_reg != 64'd0 && found_reg;
                end
                ttlrc_pkg::OP_RELEASE: begin
                    head_sel    = rel_ok && cnt_reg[IW-1:0] == IW'(sin_reg);
                    upd.dec_ref = 1'b1;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ttlrc_pkg::S_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
        found_reg     <= found_next;
        tgt_reg       <= tgt_next;
        stop_reg      <= stop_next;
        oldest_reg    <= oldest_next;
        valid_age_reg <= valid_age_next;
        hrows_reg     <= hrows_next;
        hcols_reg     <= hcols_next;
    end

    // Capture the item
    always_ff @(posedge aclk) begin
        if (in_acc) begin
            op_reg    <= s_tdata[2:0];
            key_reg   <= s_tdata[66:3];
            now_reg   <= s_tdata[130:67];
            sin_reg   <= s_tdata[134:131];
            ok_reg    <= s_tdata[135];
            rows_reg  <= s_tdata[151:136];
            cols_reg  <= s_tdata[163:152];
            bytes_reg <= s_tdata[195:164];
        end
    end

    // Result register and totals
    logic [3:0]  st_c;
    logic [3:0]  sl_c;
    logic [15:0] tgt_ext;
    assign tgt_ext = 16'(tgt_reg);

    always_comb begin
        st_c = ttlrc_pkg::ST_SKIPPED;
        sl_c = '0;
        case (op_reg)
            ttlrc_pkg::OP_LOOKUP: begin
                st_c = lk_hit ? ttlrc_pkg::ST_HIT : ttlrc_pkg::ST_MISS;
                sl_c = lk_hit ? tgt_ext[3:0] : 4'd0;
            end
            ttlrc_pkg::OP_STORE: begin
                if (store_ok) begin
                    if (bytes_reg > max_bytes_reg) begin
                        st_c = ttlrc_pkg::ST_EVICT_SKIP;
                    end else begin
                        st_c = ttlrc_pkg::ST_STORED;
                        sl_c = tgt_ext[3:0];
                    end
                end
            end
            ttlrc_pkg::OP_INVALIDATE: begin
                if (key_reg != 64'd0 && found_reg) begin
                    st_c = ttlrc_pkg::ST_INVALIDATED;
                    sl_c = tgt_ext[3:0];
                end else begin
                    st_c = ttlrc_pkg::ST_NOT_FOUND;
                end
            end
            ttlrc_pkg::OP_RELEASE: begin
                st_c = rel_ok ? ttlrc_pkg::ST_RELEASED : ttlrc_pkg::ST_NOT_FOUND;
                sl_c = rel_ok ? sin_reg : 4'd0;
            end
            ttlrc_pkg::OP_TOTALS: st_c = ttlrc_pkg::ST_TOTALS;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mv_reg       <= 1'b0;
            hit_tot_reg  <= '0;
            miss_tot_reg <= '0;
        end else begin
            if (state_reg == ttlrc_pkg::S_OUT) begin
                mv_reg <= 1'b1;
                if (lk_hit) begin
                    hit_tot_reg <= hit_tot_reg + 64'd1;
                end else if (op_reg == ttlrc_pkg::OP_LOOKUP && key_reg != 64'd0) begin
                    miss_tot_reg <= miss_tot_reg + 64'd1;
                end
            end else if (mv_reg && m_tready) begin
                mv_reg <= 1'b0;
            end
        end
        if (state_reg == ttlrc_pkg::S_OUT) begin
            status_reg   <= st_c;
            slot_out_reg <= sl_c;
            rout_reg     <= lk_hit ? hrows_reg : 16'd0;
            cout_reg     <= lk_hit ? hcols_reg : 12'd0;
        end
    end

    assign m_tvalid = mv_reg;
    assign m_tdata  = {4'd0, miss_tot_reg, hit_tot_reg, cout_reg, rout_reg,
                       slot_out_reg, status_reg};

    // Checks
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !m_tvalid)
        else $error("input taken while a result is pending");
    a_scan_len: assert property (@(posedge aclk) disable iff (!aresetn)
        in_acc |=> state_reg == ttlrc_pkg::S_SCAN && cnt_reg == '0)
        else $error("scan did not start at slot zero");
    a_totals: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ttlrc_pkg::S_OUT) |=> $stable(hit_tot_reg))
        else $error("hit total moved outside result cycle");

endmodule

@@ tb/tb.sv @@
// Self-checking bench for the TTL result cache tag table unit.
// Drives opcode transactions, predicts each result with a local tag-table
// model and compares it; depends on ttlrc_pkg and the unit RTL.
module tb;

    localparam int SLOTS = 16;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    // opcode, key, now_ms, slot_in, query_ok, row_count, col_count, byte_count
    logic [199:0] s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    // status, slot_out, rows_out, cols_out, hit_total, miss_total
    logic [167:0] m_tdata;
    logic         cfg_we = 1'b0;
    logic [1:0]   cfg_index = '0;
    logic [31:0]  cfg_wdata = '0;

    typedef struct packed {
        logic [63:0] miss;
        logic [63:0] hit;
        logic [11:0] cols;
        logic [15:0] rows;
        logic [3:0]  slot;
        logic [3:0]  status;
    } reply_t;

    ttl_refcount_result_cache_tags_unit #(.ENTRIES(SLOTS)) dut (.*);

    // Clock
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Predicted table contents
    logic [31:0] p_ttl;
    logic [15:0] p_max_rows;
    logic [31:0] p_max_bytes;
    logic [63:0] t_key [SLOTS];
    logic [63:0] t_made [SLOTS];
    logic [15:0] t_refs [SLOTS];
    logic [31:0] t_hits [SLOTS];
    logic [15:0] t_rows [SLOTS];
    logic [11:0] t_cols [SLOTS];
    logic [63:0] hits_seen, miss_count;

    reply_t pending_replies [$];
    int     mismatches = 0;
    bit     quiet_src = 0, quiet_snk = 0;
    logic [63:0] key_pool [8];
    logic [63:0] clock_ms;

    task automatic clear_unreferenced(int s);
        if (t_refs[s] == 0) begin
            t_key[s] = '0;
            t_rows[s] = '0;
            t_cols[s] = '0;
        end
    endtask

    // Predict the reply of one transaction and update the table copy
    task automatic predict_reply(logic [2:0] op, logic [63:0] key, logic [63:0] now,
                                 logic [3:0] sl, logic ok, logic [15:0] rows,
                                 logic [11:0] cols, logic [31:0] bytes);
        reply_t r;
        int     i, tgt;
        bit     found, chosen;
        logic [63:0] oldest;
        r = '0;
        r.status = ttlrc_pkg::ST_SKIPPED;
        case (op)
            ttlrc_pkg::OP_LOOKUP: begin
                r.status = ttlrc_pkg::ST_MISS;
                if (key != 0) begin
                    found = 0;
                    tgt = 0;
                    for (i = 0; i < SLOTS && !found; i++)
                        if (t_key[i] == key) begin
                            found = 1;
                            tgt = i;
                        end
                    if (found && (now - t_made[tgt]) < {32'd0, p_ttl}) begin
                        if (t_refs[tgt] != 16'hFFFF) t_refs[tgt]++;
                        t_hits[tgt]++;
                        hits_seen++;
                        r.status = ttlrc_pkg::ST_HIT;
                        r.slot = tgt[3:0];
                        r.rows = t_rows[tgt];
                        r.cols = t_cols[tgt];
                    end else begin
                        if (found) clear_unreferenced(tgt);
                        miss_count++;
                    end
                end
            end
            ttlrc_pkg::OP_STORE: begin
                if (ok && rows != 0 && rows <= p_max_rows && key != 0) begin
                    tgt = 0;
                    chosen = 0;
                    found = 0;
                    oldest = '1;
                    for (i = 0; i < SLOTS && !found; i++) begin
                        if (t_key[i] == key || t_key[i] == 0) begin
                            tgt = i;
                            found = 1;
                        end else if (t_made[i] < oldest) begin
                            oldest = t_made[i];
                            tgt = i;
                            chosen = 1;
                        end
                    end
                    if (!found && !chosen) tgt = 0;
                    clear_unreferenced(tgt);
                    if (bytes > p_max_bytes) begin
                        r.status = ttlrc_pkg::ST_EVICT_SKIP;
                    end else begin
                        t_key[tgt] = key;
                        t_made[tgt] = now;
                        t_refs[tgt] = 0;
                        t_rows[tgt] = rows;
                        t_cols[tgt] = cols;
                        t_hits[tgt] = 0;
                        r.status = ttlrc_pkg::ST_STORED;
                        r.slot = tgt[3:0];
                    end
                end
            end
            ttlrc_pkg::OP_INVALIDATE: begin
                r.status = ttlrc_pkg::ST_NOT_FOUND;
                found = 0;
                if (key != 0)
                    for (i = 0; i < SLOTS && !found; i++)
                        if (t_key[i] == key) begin
                            clear_unreferenced(i);
                            r.status = ttlrc_pkg::ST_INVALIDATED;
                            r.slot = i[3:0];
                            found = 1;
                        end
            end
            ttlrc_pkg::OP_RELEASE: begin
                if (int'(sl) < SLOTS) begin
                    if (t_refs[sl] != 0) t_refs[sl]--;
                    r.status = ttlrc_pkg::ST_RELEASED;
                    r.slot = sl;
                end else begin
                    r.status = ttlrc_pkg::ST_NOT_FOUND;
                end
            end
            ttlrc_pkg::OP_TOTALS: r.status = ttlrc_pkg::ST_TOTALS;
            default: ;
        endcase
        r.hit = hits_seen;
        r.miss = miss_count;
        pending_replies.push_back(r);
    endtask

    // Send one transaction; prediction is made at acceptance
    task automatic send_op(logic [2:0] op, logic [63:0] key, logic [63:0] now,
                           logic [3:0] sl, logic ok, logic [15:0] rows,
                           logic [11:0] cols, logic [31:0] bytes);
        while (!quiet_src && $urandom_range(99) < 13) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tdata <= {4'd0, bytes, cols, rows, ok, sl, now, key, op};
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_reply(op, key, now, sl, ok, rows, cols, bytes);
    endtask

    // Drop valid and wait for every outstanding reply
    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_replies.size() != 0) @(posedge aclk);
        repeat (2 * SLOTS + 8) @(posedge aclk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        @(posedge aclk);
        case (idx)
            ttlrc_pkg::CFG_TTL:       p_ttl = val;
            ttlrc_pkg::CFG_MAX_ROWS:  p_max_rows = val[15:0];
            ttlrc_pkg::CFG_MAX_BYTES: p_max_bytes = val;
            default: ;
        endcase
    endtask

    // Sink: random stall, compare each reply with the oldest prediction
    always @(posedge aclk) begin
        reply_t got, want;
        if (m_tvalid && m_tready) begin
            got = m_tdata[163:0];
            if (pending_replies.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected reply %h", got);
            end else begin
                want = pending_replies.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: exp st=%0d sl=%0d r=%0d c=%0d h=%0d m=%0d",
                                  " | got st=%0d sl=%0d r=%0d c=%0d h=%0d m=%0d"},
                                 want.status, want.slot, want.rows, want.cols,
                                 want.hit, want.miss, got.status, got.slot,
                                 got.rows, got.cols, got.hit, got.miss);
                end
            end
        end
        m_tready <= quiet_snk || ($urandom_range(99) >= 13);
    end

    task automatic test_directed();
        clock_ms = 64'd5000;
        send_op(ttlrc_pkg::OP_LOOKUP, 64'd0, clock_ms, '0, 1'b0, '0, '0, '0);
        send_op(ttlrc_pkg::OP_TOTALS, 64'd0, clock_ms, '0, 1'b0, '0, '0, '0);
        send_op(ttlrc_pkg::OP_STORE, 64'd7, clock_ms, '0, 1'b0, 16'd5, 12'd3, 32'd10);
        send_op(ttlrc_pkg::OP_STORE, 64'd7, clock_ms, '0, 1'b1, 16'd0, 12'd3, 32'd10);
        send_op(ttlrc_pkg::OP_STORE, 64'd7, clock_ms, '0, 1'b1, 16'd1001, 12'd3,
                32'd10);
        send_op(ttlrc_pkg::OP_STORE, 64'd0, clock_ms, '0, 1'b1, 16'd5, 12'd3, 32'd10);
        send_op(ttlrc_pkg::OP_STORE, 64'd7, clock_ms, '0, 1'b1, 16'd1000, 12'hFFF,
                32'd1048576);
        send_op(ttlrc_pkg::OP_STORE, 64'd9, clock_ms, '0, 1'b1, 16'd1, 12'd0,
                32'hFFFFFFFF);
        send_op(ttlrc_pkg::OP_STORE, '1, '1, '0, 1'b1, 16'd2, 12'd2, 32'd0);
        send_op(ttlrc_pkg::OP_LOOKUP, 64'd7, clock_ms + 64'd999, '0, 1'b0, '0, '0, '0);
        send_op(ttlrc_pkg::OP_LOOKUP, 64'd7, clock_ms + 64'd10, '0, 1'b0, '0, '0, '0);
        send_op(ttlrc_pkg::OP_INVALIDATE, 64'd7, clock_ms, '0, 1'b0, '0, '0, '0);
        send_op(ttlrc_pkg::OP_RELEASE, 64'd0, clock_ms, 4'd0, 1'b0, '0, '0, '0);
        send_op(ttlrc_pkg::OP_RELEASE, 64'd0, clock_ms, 4'd0, 1'b0, '0, '0, '0);
        send_op(ttlrc_pkg::OP_RELEASE, 64'd0, clock_ms, 4'd0, 1'b0, '0, '0, '0);
        send_op(ttlrc_pkg::OP_RELEASE, 64'd0, clock_ms, 4'd15, 1'b0, '0, '0, '0);
        send_op(ttlrc_pkg::OP_LOOKUP, 64'd7, clock_ms + 64'd1000, '0, 1'b0, '0, '0, '0);
        send_op(ttlrc_pkg::OP_INVALIDATE, 64'd7, clock_ms, '0, 1'b0, '0, '0, '0);
        send_op(ttlrc_pkg::OP_INVALIDATE, 64'd0, clock_ms, '0, 1'b0, '0, '0, '0);
        send_op(ttlrc_pkg::OP_INVALIDATE, 64'd12345, clock_ms, '0, 1'b0, '0, '0, '0);
        send_op(3'd5, 64'd1, clock_ms, '0, 1'b1, 16'd1, 12'd1, 32'd1);
        send_op(3'd6, 64'd1, clock_ms, '0, 1'b1, 16'd1, 12'd1, 32'd1);
        send_op(3'd7, '1, '1, '1, 1'b1, '1, '1, '1);
        // Hold off until every reply has come back
        drain();
    endtask

    // Random stream mostly over a small key pool so entries get reused
    task automatic test_random(int count, bit wide_time);
        int n;
        logic [2:0]  op;
        logic [63:0] key, now;
        logic [15:0] rows;
        for (n = 0; n < count; n++) begin
            quiet_src = (n >= count / 2 && n < count / 2 + 100);
            quiet_snk = quiet_src;
            clock_ms += $urandom_range(wide_time ? 400 : 40);
            now = ($urandom_range(19) == 0) ? {$urandom, $urandom} : clock_ms;
            key = ($urandom_range(9) == 0) ? {$urandom, $urandom}
                  : ($urandom_range(19) == 0) ? 64'd0 : key_pool[$urandom_range(7)];
            case ($urandom_range(9))
                0, 1, 2, 3: op = ttlrc_pkg::OP_LOOKUP;
                4, 5, 6:    op = ttlrc_pkg::OP_STORE;
                7:          op = ttlrc_pkg::OP_INVALIDATE;
                8:          op = ttlrc_pkg::OP_RELEASE;
                default:    op = 3'($urandom_range(7));
            endcase
            rows = ($urandom_range(7) == 0) ? 16'($urandom) : 16'($urandom_range(1, 50));
            send_op(op, key, now, 4'($urandom), ($urandom_range(7) != 0), rows,
                    12'($urandom), ($urandom_range(7) == 0) ? $urandom : $urandom_range(5000));
        end
        quiet_src = 0;
        quiet_snk = 0;
        drain();
    endtask

    initial begin
        int k;
        p_ttl = 32'd1000;
        p_max_rows = 16'd1000;
        p_max_bytes = 32'd1048576;
        for (k = 0; k < SLOTS; k++) begin
            t_key[k] = 0; t_made[k] = 0; t_refs[k] = 0;
            t_hits[k] = 0; t_rows[k] = 0; t_cols[k] = 0;
        end
        hits_seen = 0;
        miss_count = 0;
        for (k = 0; k < 8; k++) key_pool[k] = {$urandom, $urandom} | 64'd1;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2 * SLOTS + 4) @(posedge aclk);

        test_directed();
        test_random(500, 0);
        write_reg(ttlrc_pkg::CFG_TTL, 32'd1);
        write_reg(ttlrc_pkg::CFG_MAX_ROWS, 32'h0000FFFF);
        write_reg(ttlrc_pkg::CFG_MAX_BYTES, 32'hFFFFFFFF);
        test_random(350, 0);
        write_reg(ttlrc_pkg::CFG_TTL, 32'hFFFFFFFF);
        write_reg(ttlrc_pkg::CFG_MAX_ROWS, 32'd1);
        write_reg(ttlrc_pkg::CFG_MAX_BYTES, 32'd1);
        test_random(350, 1);
        write_reg(ttlrc_pkg::CFG_TTL, 32'd300);
        write_reg(ttlrc_pkg::CFG_MAX_ROWS, 32'd40);
        write_reg(ttlrc_pkg::CFG_MAX_BYTES, 32'd3000);
        test_random(400, 1);

        if (mismatches == 0 && pending_replies.size() == 0)
            $display("ttl_refcount_result_cache_tags_unit verification clean");
        else
            $display("ttl_refcount_result_cache_tags_unit verification failed");
        $finish;
    end

    // Watchdog
    initial begin
        #800000;
        $display("ttl_refcount_result_cache_tags_unit verification failed");
        $finish;
    end
endmodule

@@ filelist.f @@
hw/rtl/ttlrc_pkg.sv
hw/rtl/ttlrc_cell.sv
hw/rtl/ttl_refcount_result_cache_tags_unit.sv
tb/tb.sv
